/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dedup unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and active-low reset.
`define PDD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds in the cycle after the condition.
`define PDD_ASSERT_STABLE(name, clk, rst_n, cond, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

/* rtl/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// Polyline point dedup package
// Types, constants and distance helpers shared by the dedup unit modules.
// ----------------------------------------------------------------------------
package pdd_pkg;

	localparam int COORD_W = 32;
	localparam int TOL_W   = 41;
	localparam int SAT_W   = 21;
	localparam int SQ_W    = 41;
	localparam int SUM_W   = 43;

	// Difference magnitude saturates at 2^20 before squaring.
	localparam logic [SAT_W-1:0] DIFF_SAT = 21'h100000;

	localparam int PENDING_DEPTH_DEF = 8;
	localparam int CMD_QUEUE_DEPTH   = 4;
	localparam int RES_QUEUE_DEPTH   = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 41;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_MODE = 2'd0,
		CFG_CLOSED   = 2'd1,
		CFG_TOL      = 2'd2
	} cfg_reg_t;

	localparam logic [1:0]       DIM_2D       = 2'd2;
	localparam logic [1:0]       DIM_MODE_RST = 2'd3;
	localparam logic             CLOSED_RST   = 1'b0;
	localparam logic [TOL_W-1:0] TOL_RST      = 41'd43;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      final_vertex;
	} vertex_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      carries_point;
		logic                      run_last;
		logic                      polyline_end;
		logic                      pending_overflow;
	} result_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef enum logic [1:0] {
		CMD_DROP,
		CMD_KEEP,
		CMD_PEND
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      final_vertex;
		point_t    pt;
	} cmd_word_t;

	localparam int CMD_W = $bits(cmd_word_t);
	localparam int RES_W = $bits(result_word_t);

	// Exact difference, magnitude, saturate at 2^20.
	function automatic logic [SAT_W-1:0] sat_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        mag;
		d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		mag = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
		return (mag > (COORD_W+1)'(DIFF_SAT)) ? DIFF_SAT : mag[SAT_W-1:0];
	endfunction

	function automatic logic [SQ_W-1:0] square(input logic [SAT_W-1:0] m);
		logic [SQ_W-1:0] w;
		w = SQ_W'(m);
		return w * w;
	endfunction

	function automatic result_word_t point_word(input point_t p, input logic last,
			input logic fin, input logic ovf);
		result_word_t r;
		r.out_x            = p.x;
		r.out_y            = p.y;
		r.out_z            = p.z;
		r.carries_point    = 1'b1;
		r.run_last         = last;
		r.polyline_end     = fin;
		r.pending_overflow = ovf;
		return r;
	endfunction

	function automatic result_word_t end_word();
		result_word_t r;
		r              = '0;
		r.run_last     = 1'b1;
		r.polyline_end = 1'b1;
		return r;
	endfunction

endpackage

/* rtl/polyline_point_dedup_unit.sv */
// ----------------------------------------------------------------------------
// Polyline point dedup unit
// Removes repeated vertices from a polyline stream, trims closing vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Vertex channel: drive vertex and raise push; the word is taken at a clock
//   edge with push high and full low. Raise final_vertex on the last vertex of
//   each polyline. Result channel: while empty is low, result holds the oldest
//   result word; raise pop to take it. Write configuration only while idle.
//   A vertex yields zero or more words (up to PENDING_DEPTH + 1 when the pending
//   buffer flushes). The last word of a vertex has run_last set; the last word of
//   a polyline has polyline_end set, or is an end-only word with no point.
// Timing:
//   The front end takes one vertex per cycle while full is low. Its near/far decision loop closes
//   in the second stage with forwarding of the vertex ahead, so there is no
//   bubble between vertices. The back end emits one word per cycle while the result
//   queue has room; a vertex that flushes N pending vertices gives N + 1 words.
//   A first result word passes stage 1, stage 2, the command and result queues.
// Reset and stall:
//   Reset empties all queues, clears the pending count and starts a new
//   polyline; registers return to dimension 3, open curve, tolerance 43.
//   When pop stays low the result queue fills, the back end holds, the command
//   queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module polyline_point_dedup_unit import pdd_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  vertex_word_t          vertex,
	output logic                  empty,
	input  logic                  pop,
	output result_word_t          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0]       dimension_mode_q;
	logic             closed_curve_q;
	logic [TOL_W-1:0] tolerance_sq_q;

	logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_word_t        cmd_wr, cmd_rd;
	logic [CMD_W-1:0] cmd_rd_bits;

	logic             res_push, res_full;
	result_word_t     res_wr;
	logic [RES_W-1:0] res_rd_bits;

	// Configuration registers: write-only, indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_mode_q <= DIM_MODE_RST;
			closed_curve_q   <= CLOSED_RST;
			tolerance_sq_q   <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DIM_MODE: dimension_mode_q <= cfg_data[1:0];
				CFG_CLOSED:   closed_curve_q   <= cfg_data[0];
				CFG_TOL:      tolerance_sq_q   <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept and classify each vertex.
	pdd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.vertex         (vertex),
		.dimension_mode (dimension_mode_q),
		.closed_curve   (closed_curve_q),
		.tolerance_sq   (tolerance_sq_q),
		.cmd_full       (cmd_full),
		.cmd_push       (cmd_push),
		.cmd            (cmd_wr)
	);

	// Command queue decouples classification from emission.
	pdd_queue #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd_bits),
		.empty   (cmd_empty)
	);

	assign cmd_rd = cmd_word_t'(cmd_rd_bits);

	// Back: pending buffer and word sequencing.
	pdd_back #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	// Result queue: holds finished words while the receiver stalls.
	pdd_queue #(
		.WIDTH (RES_W),
		.DEPTH (RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rd_bits),
		.empty   (empty)
	);

	assign result = result_word_t'(res_rd_bits);

endmodule

/* rtl/pdd_queue.sv */
// ----------------------------------------------------------------------------
// Dedup queue
// Small first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module pdd_queue import pdd_pkg::*; #(
	parameter int WIDTH = CMD_W,
	parameter int DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;
	logic [PW-1:0]    wr_next, rd_next;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem[rd_ptr_q];
	assign wr_next = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_next;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_next;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/pdd_front.sv */
// ----------------------------------------------------------------------------
// Dedup front end
// Accepts vertices, runs the distance tests and classifies each vertex.
// ----------------------------------------------------------------------------
module pdd_front import pdd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  vertex_word_t     vertex,
	input  logic [1:0]       dimension_mode,
	input  logic             closed_curve,
	input  logic [TOL_W-1:0] tolerance_sq,
	input  logic             cmd_full,
	output logic             cmd_push,
	output cmd_word_t        cmd
);

	// Stage 1: accepted vertex
	logic        valid_s1;
	point_t      pt_s1;
	logic        final_s1, first_s1;

	// Stage 2: squared differences, decision
	logic            valid_s2;
	point_t          pt_s2;
	logic            final_s2, first_s2;
	logic [SQ_W-1:0] sql_s2 [3];
	logic [SQ_W-1:0] sqf_s2 [3];

	logic   first_next_q;
	point_t first_pt_q, last_pt_q;

	logic            accept, s1_move, s2_free, need_cmd, use_prev;
	logic            near_last, near_first, keep_s2;
	cmd_kind_t       kind_s2;
	logic [SUM_W-1:0] sum_last, sum_first;
	logic [SQ_W-1:0] sql_now [3];
	logic [SQ_W-1:0] sqf_now [3];
	point_t          pt_in;

	assign pt_in.x = vertex.coord_x;
	assign pt_in.y = vertex.coord_y;
	assign pt_in.z = (dimension_mode == DIM_2D) ? '0 : vertex.coord_z;

	assign sum_last  = SUM_W'(sql_s2[0]) + SUM_W'(sql_s2[1]) + SUM_W'(sql_s2[2]);
	assign sum_first = SUM_W'(sqf_s2[0]) + SUM_W'(sqf_s2[1]) + SUM_W'(sqf_s2[2]);
	assign near_last  = (sum_last <= SUM_W'(tolerance_sq));
	assign near_first = (sum_first <= SUM_W'(tolerance_sq));
	assign keep_s2    = first_s2 || !near_last;

	always_comb begin
		if (!keep_s2) begin
			kind_s2 = CMD_DROP;
		end else if (!first_s2 && closed_curve && near_first) begin
			kind_s2 = CMD_PEND;
		end else begin
			kind_s2 = CMD_KEEP;
		end
	end

	// A dropped vertex that does not end the polyline leaves nothing for the back end.
	assign need_cmd = (kind_s2 != CMD_DROP) || final_s2;
	assign s2_free  = !valid_s2 || !need_cmd || !cmd_full;
	assign s1_move  = valid_s1 && s2_free;
	assign full     = valid_s1 && !s2_free;
	assign accept   = push && !full;

	assign cmd_push         = valid_s2 && need_cmd && !cmd_full;
	assign cmd.kind         = kind_s2;
	assign cmd.final_vertex = final_s2;
	assign cmd.pt           = pt_s2;

	// The vertex in stage 2 resolves in the same cycle; if it is kept it becomes
	// the reference for the vertex moving up.
	assign use_prev = valid_s2 && keep_s2;

	always_comb begin
		sql_now[0] = use_prev ? square(sat_diff(pt_s1.x, pt_s2.x))
				: square(sat_diff(pt_s1.x, last_pt_q.x));
		sql_now[1] = use_prev ? square(sat_diff(pt_s1.y, pt_s2.y))
				: square(sat_diff(pt_s1.y, last_pt_q.y));
		sql_now[2] = use_prev ? square(sat_diff(pt_s1.z, pt_s2.z))
				: square(sat_diff(pt_s1.z, last_pt_q.z));
		sqf_now[0] = square(sat_diff(pt_s1.x, first_pt_q.x));
		sqf_now[1] = square(sat_diff(pt_s1.y, first_pt_q.y));
		sqf_now[2] = square(sat_diff(pt_s1.z, first_pt_q.z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			first_next_q <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1     <= 1'b1;
				first_next_q <= vertex.final_vertex;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_s1    <= pt_in;
			final_s1 <= vertex.final_vertex;
			first_s1 <= first_next_q;
			if (first_next_q) begin
				first_pt_q <= pt_in;
			end
		end
		if (s1_move) begin
			pt_s2    <= pt_s1;
			final_s2 <= final_s1;
			first_s2 <= first_s1;
			sql_s2   <= sql_now;
			sqf_s2   <= sqf_now;
		end
		if (valid_s2 && s2_free && keep_s2) begin
			last_pt_q <= pt_s2;
		end
	end

endmodule

/* rtl/pdd_back.sv */
// ----------------------------------------------------------------------------
// Dedup back end
// Holds the pending buffer and turns commands into result words.
// ----------------------------------------------------------------------------
module pdd_back import pdd_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_empty,
	input  cmd_word_t    cmd,
	output logic         cmd_pop,
	input  logic         res_full,
	output logic         res_push,
	output result_word_t res
);

	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int SW = ((PW > CW) ? PW : CW) + 1;

	point_t        pend_mem [PENDING_DEPTH];
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;

	point_t        head_pt;
	logic          count_zero, count_full;
	logic [SW-1:0] tail_sum, tail_wrap;
	logic [PW-1:0] tail_idx, head_next;
	logic          pop_head, wr_pend, clear_pend;

	assign head_pt    = pend_mem[head_q];
	assign count_zero = (count_q == '0);
	assign count_full = (count_q == CW'(PENDING_DEPTH));
	assign tail_sum   = SW'(head_q) + SW'(count_q);
	assign tail_wrap  = (tail_sum >= SW'(PENDING_DEPTH)) ? tail_sum - SW'(PENDING_DEPTH) : tail_sum;
	assign tail_idx   = tail_wrap[PW-1:0];
	assign head_next  = (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		res        = '0;
		res_push   = 1'b0;
		cmd_pop    = 1'b0;
		pop_head   = 1'b0;
		wr_pend    = 1'b0;
		clear_pend = 1'b0;
		if (!cmd_empty) begin
			case (cmd.kind)
				CMD_KEEP: begin
					if (!count_zero) begin
						// flush oldest pending word first
						res      = point_word(head_pt, 1'b0, 1'b0, 1'b0);
						res_push = !res_full;
						pop_head = !res_full;
					end else begin
						res      = point_word(cmd.pt, 1'b1, cmd.final_vertex, 1'b0);
						res_push = !res_full;
						cmd_pop  = !res_full;
					end
				end
				CMD_PEND: begin
					if (count_full) begin
						// evict oldest, new vertex takes its slot
						res        = point_word(head_pt, 1'b1, cmd.final_vertex, 1'b1);
						res_push   = !res_full;
						cmd_pop    = !res_full;
						pop_head   = !res_full;
						wr_pend    = !res_full;
						clear_pend = !res_full && cmd.final_vertex;
					end else if (cmd.final_vertex) begin
						res        = end_word();
						res_push   = !res_full;
						cmd_pop    = !res_full;
						clear_pend = !res_full;
					end else begin
						cmd_pop = 1'b1;
						wr_pend = 1'b1;
					end
				end
				CMD_DROP: begin
					if (cmd.final_vertex) begin
						res        = end_word();
						res_push   = !res_full;
						cmd_pop    = !res_full;
						clear_pend = !res_full;
					end else begin
						cmd_pop = 1'b1;
					end
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_pend) begin
			pend_mem[tail_idx] <= cmd.pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop_head) begin
				head_q <= head_next;
			end
			if (clear_pend) begin
				count_q <= '0;
			end else begin
				case ({wr_pend, pop_head})
					2'b10: count_q <= count_q + 1'b1;
					2'b01: count_q <= count_q - 1'b1;
					default: count_q <= count_q;
				endcase
			end
		end
	end

endmodule

/* rtl/pdd_checker.sv */
// ----------------------------------------------------------------------------
// Dedup unit checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdd_checker import pdd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         empty,
	input logic         pop,
	input result_word_t result
);

	logic end_word_ok;

	assign end_word_ok = result.run_last && result.polyline_end && !result.pending_overflow
			&& (result.out_x == 0) && (result.out_y == 0) && (result.out_z == 0);

	// End-only word carries no point and closes the polyline.
	`PDD_ASSERT(a_end_only_form, clk, arst_n, (!empty && !result.carries_point) |-> end_word_ok, "end-only word malformed")

	// Polyline end is always the last word of its vertex.
	`PDD_ASSERT(a_end_is_last, clk, arst_n, (!empty && result.polyline_end) |-> result.run_last, "polyline end without run_last")

	// Overflow eviction always carries a point.
	`PDD_ASSERT(a_ovf_has_point, clk, arst_n, (!empty && result.pending_overflow) |-> result.carries_point, "overflow word without point")

	// Stalled word stays presented and unchanged.
	`PDD_ASSERT(a_word_stays, clk, arst_n, (!empty && !pop) |=> !empty, "result withdrawn while stalled")
	`PDD_ASSERT_STABLE(a_word_holds, clk, arst_n, !empty && !pop, result, "result changed while stalled")

endmodule

bind polyline_point_dedup_unit pdd_checker u_pdd_checker (.*);

/* verif/tb_polyline_point_dedup_unit.sv */
// ----------------------------------------------------------------------------
// Polyline point dedup unit testbench
// Pushes vertex words into the unit and predicts every kept, trimmed,
// overflow and end-marker word with a behavioral model of the dedup rules.
// Each popped result word is checked in order. Both sides idle in random
// bursts, with one long result hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_polyline_point_dedup_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import pdd_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int CLOSE_DEPTH     = PENDING_DEPTH_DEF;
	localparam longint SAT_LIMIT   = 64'd1 << 20;
	localparam int DRAIN_CYCLES    = 16;
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int RANDOM_VERTICES = 360;
	localparam int STEADY_VERTICES = 60;

	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
	localparam logic [CFG_DATA_W-1:0]     TOL_MAX = 41'd1 << 40;

	// Out-of-range dimension codes; both must behave as full 3D.
	localparam logic [1:0] DIM_SPARE0 = 2'd0;
	localparam logic [1:0] DIM_SPARE1 = 2'd1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	vertex_word_t          vertex;
	logic                  empty;
	logic                  pop;
	result_word_t          result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Behavioral copy of the unit's registers and polyline state.
	logic [1:0]            dim_mode    = DIM_MODE_RST;
	logic                  closed_mode = CLOSED_RST;
	logic [CFG_DATA_W-1:0] tol_sq      = TOL_RST;
	bit                    line_open   = 1'b0;
	point_t                anchor_pt;
	point_t                last_kept_pt;
	point_t                closing_pts[$];

	result_word_t predicted_words[$];

	int errors        = 0;
	int cycle_count   = 0;
	int vertices_sent = 0;
	bit idle_enabled  = 1'b1;
	bit hold_results  = 1'b0;

	polyline_point_dedup_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.vertex    (vertex),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Squared distance with each axis difference clamped at 2^20, then
	// compared against the coincidence tolerance.
	function automatic bit is_coincident(point_t a, point_t b);
		longint           d[3];
		longint unsigned  sum;
		d[0] = longint'(a.x) - longint'(b.x);
		d[1] = longint'(a.y) - longint'(b.y);
		d[2] = longint'(a.z) - longint'(b.z);
		sum = 0;
		foreach (d[k]) begin
			if (d[k] < 0)
				d[k] = -d[k];
			if (d[k] > SAT_LIMIT)
				d[k] = SAT_LIMIT;
			sum += longint'(d[k] * d[k]);
		end
		return sum <= longint'(tol_sq);
	endfunction

	function automatic result_word_t kept_word(point_t p, logic ovf);
		result_word_t r;
		r                  = '0;
		r.out_x            = p.x;
		r.out_y            = p.y;
		r.out_z            = p.z;
		r.carries_point    = 1'b1;
		r.pending_overflow = ovf;
		return r;
	endfunction

	// Work out the words one accepted vertex causes and queue them.
	function automatic void predict_dedup(vertex_word_t w);
		point_t       p;
		result_word_t burst[$];
		result_word_t tail;
		p.x = w.coord_x;
		p.y = w.coord_y;
		p.z = (dim_mode == DIM_2D) ? '0 : w.coord_z;
		if (!line_open) begin
			// Open a new polyline: the first vertex always goes out.
			line_open    = 1'b1;
			anchor_pt    = p;
			last_kept_pt = p;
			closing_pts.delete();
			burst = {burst, kept_word(p, 1'b0)};
		end else if (!is_coincident(last_kept_pt, p)) begin
			last_kept_pt = p;
			if (closed_mode && is_coincident(anchor_pt, p)) begin
				// Hold vertices near the start; emit the oldest when full.
				if (closing_pts.size() >= CLOSE_DEPTH)
					burst = {burst, kept_word(closing_pts.pop_front(), 1'b1)};
				closing_pts = {closing_pts, p};
			end else begin
				// A far vertex releases everything held, in order, ahead of it.
				foreach (closing_pts[i])
					burst = {burst, kept_word(closing_pts[i], 1'b0)};
				closing_pts.delete();
				burst = {burst, kept_word(p, 1'b0)};
			end
		end
		if (w.final_vertex) begin
			// Drop what is still held; a silent final vertex gets an end marker.
			line_open = 1'b0;
			closing_pts.delete();
			if (burst.size() == 0) begin
				tail  = '0;
				burst = {burst, tail};
			end
			tail              = burst.pop_back();
			tail.polyline_end = 1'b1;
			burst             = {burst, tail};
		end
		if (burst.size() != 0) begin
			tail          = burst.pop_back();
			tail.run_last = 1'b1;
			burst         = {burst, tail};
		end
		predicted_words = {predicted_words, burst};
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
		end
	endtask

	// Check every popped word against the oldest prediction.
	always @(posedge clk) begin : result_check
		result_word_t want;
		if (arst_n && !empty && pop) begin
			if (predicted_words.size() == 0) begin
				errors++;
				$display("%0t: word %h popped with nothing predicted", $time, result);
			end else begin
				want = predicted_words.pop_front();
				compare_field("out_x", want.out_x, result.out_x);
				compare_field("out_y", want.out_y, result.out_y);
				compare_field("out_z", want.out_z, result.out_z);
				compare_field("carries_point", 32'(want.carries_point),
					32'(result.carries_point));
				compare_field("run_last", 32'(want.run_last), 32'(result.run_last));
				compare_field("polyline_end", 32'(want.polyline_end),
					32'(result.polyline_end));
				compare_field("pending_overflow", 32'(want.pending_overflow),
					32'(result.pending_overflow));
			end
		end
	end

	// Result side: pop at random, idle in bursts, or hold off for a long
	// stretch on request so the unit backs up and raises full.
	initial begin : result_drain
		int stall;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				pop <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_results = 1'b0;
			end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 15);
				pop <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached, %0d words still predicted", $time,
				predicted_words.size());
			$display("polyline_point_dedup_unit test failed");
			$finish;
		end
	end

	// Offer one vertex word, maybe after an idle burst, and hold it until taken.
	task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, z, input logic fin);
		vertex_word_t w;
		int           gap;
		w.coord_x      = x;
		w.coord_y      = y;
		w.coord_z      = z;
		w.final_vertex = fin;
		if (idle_enabled && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			push   <= 1'b0;
			vertex <= {$urandom, $urandom, $urandom, 1'($urandom)};
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		vertex <= w;
		push   <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_dedup(w);
		vertices_sent++;
	endtask

	// Drop push and wait for every predicted word, then let dropped
	// vertices still in flight drain for the given number of cycles.
	task automatic wait_drained(int extra);
		@(negedge clk);
		push <= 1'b0;
		while (predicted_words.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIM_MODE: dim_mode    = value[1:0];
			CFG_CLOSED:   closed_mode = value[0];
			CFG_TOL:      tol_sq      = value;
			default: ;
		endcase
	endtask

	// Reconfigure only once the unit has gone quiet.
	task automatic apply_setup(logic [1:0] dim, logic closed, logic [CFG_DATA_W-1:0] tol);
		wait_drained(DRAIN_CYCLES);
		set_register(CFG_DIM_MODE, CFG_DATA_W'(dim));
		set_register(CFG_CLOSED, CFG_DATA_W'(closed));
		set_register(CFG_TOL, tol);
	endtask

	function automatic int jitter(int reach);
		return int'($urandom_range(0, 2 * reach)) - reach;
	endfunction

	// One polyline mixing repeats, small steps, returns toward the start,
	// far jumps, full-range noise and extreme coordinates.
	task automatic send_random_polyline(int len, int reach);
		logic signed [COORD_W-1:0] head[3];
		logic signed [COORD_W-1:0] prev[3];
		logic signed [COORD_W-1:0] pt[3];
		logic signed [COORD_W-1:0] extremes[4] = '{C_MAX, C_MIN, 32'sd0, -32'sd1};
		foreach (head[k])
			head[k] = $urandom;
		prev = head;
		for (int n = 0; n < len; n++) begin
			case ($urandom_range(0, 9))
				0: pt = prev;
				1, 2: foreach (pt[k]) pt[k] = prev[k] + jitter(reach);
				3, 4: foreach (pt[k]) pt[k] = head[k] + jitter(reach);
				5: pt = head;
				6: foreach (pt[k]) pt[k] = prev[k] + 4 * jitter(reach);
				7: foreach (pt[k]) pt[k] = $urandom;
				default: foreach (pt[k]) pt[k] = extremes[$urandom_range(0, 3)];
			endcase
			if (n == 0)
				head = pt;
			prev = pt;
			send_vertex(pt[0], pt[1], pt[2], n == len - 1);
		end
	endtask

	function automatic int random_length();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 12);
	endfunction

	// Reset register values: open curve, 3D, default tolerance.
	task automatic test_open_polyline();
		send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);     // one vertex is first and last at once
		send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
		send_vertex(C_MIN, C_MIN, C_MIN + 6, 1'b0); // distance 36, within 43: drop
		send_vertex(C_MIN, C_MIN + 7, C_MIN, 1'b0); // distance 49: keep
		send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
		send_vertex(32'sd5, -32'sd5, 32'sd5, 1'b0);
		send_vertex(32'sd5, -32'sd5, 32'sd5, 1'b1); // repeated final vertex: end marker only
	endtask

	task automatic test_dimension_modes();
		apply_setup(DIM_2D, CLOSED_RST, TOL_RST);
		send_vertex(32'sd1, 32'sd2, C_MAX, 1'b0);   // z forced to zero
		send_vertex(32'sd1, 32'sd2, C_MIN, 1'b0);   // differs in z only: drop
		// Switch mid-polyline; the stored vertex keeps its zero z.
		apply_setup(DIM_SPARE0, CLOSED_RST, TOL_RST);
		send_vertex(32'sd1, 32'sd2, 32'sd100, 1'b1);
		apply_setup(DIM_SPARE1, CLOSED_RST, TOL_RST);
		send_vertex(32'sd0, 32'sd0, -32'sd1, 1'b1);
	endtask

	task automatic test_tolerance_extremes();
		apply_setup(DIM_MODE_RST, CLOSED_RST, '0);
		send_vertex(32'sd3, 32'sd3, 32'sd3, 1'b0);
		send_vertex(32'sd3, 32'sd3, 32'sd3, 1'b0);  // exact repeat: drop even at zero
		send_vertex(32'sd3, 32'sd3, 32'sd4, 1'b0);  // one unit off: keep
		apply_setup(DIM_MODE_RST, CLOSED_RST, TOL_MAX);
		send_vertex(C_MAX, 32'sd3, 32'sd4, 1'b0);   // one saturated axis equals the limit: drop
		send_vertex(C_MAX, C_MAX, 32'sd4, 1'b1);    // two saturated axes exceed it: keep
	endtask

	// Closed curve, radius 100 around the start.
	task automatic test_closing_trim();
		apply_setup(DIM_2D, 1'b1, 41'd10000);
		send_vertex(32'sd0, 32'sd0, 32'sd7, 1'b0);
		send_vertex(32'sd1000, 32'sd0, 32'sd0, 1'b0);
		send_vertex(32'sd60, 32'sd0, 32'sd0, 1'b0);   // near the start: hold
		send_vertex(32'sd1000, 32'sd500, 32'sd0, 1'b0); // far: release the held one first
		// Alternate across the start so each vertex is new; the ninth overflows.
		for (int n = 0; n < CLOSE_DEPTH + 1; n++)
			send_vertex((n % 2) ? -32'sd60 : 32'sd60, 32'sd0, n, 1'b0);
		send_vertex(32'sd2000, 32'sd0, 32'sd0, 1'b0);   // flush the full buffer plus itself
		send_vertex(32'sd60, 32'sd0, 32'sd0, 1'b1);     // held at the final vertex: trimmed
	endtask

	task automatic test_result_backpressure();
		apply_setup(DIM_MODE_RST, CLOSED_RST, TOL_RST);
		idle_enabled = 1'b0;
		hold_results = 1'b1;
		// Keep offering while results are held, so full must rise.
		repeat (30) send_vertex($urandom, $urandom, $urandom, 1'b0);
		// Pause mid-polyline until every word is out, then finish the polyline.
		wait_drained(0);
		repeat (9) send_vertex($urandom, $urandom, $urandom, 1'b0);
		send_vertex($urandom, $urandom, $urandom, 1'b1);
		idle_enabled = 1'b1;
	endtask

	task automatic test_random_polylines();
		int                    goal;
		int                    reach;
		longint                reach_sq;
		logic [CFG_DATA_W-1:0] tol;
		int                    reaches[8] = '{1, 3, 7, 40, 1000, 60000, 1 << 20, 1 << 21};
		goal = vertices_sent + RANDOM_VERTICES;
		while (vertices_sent < goal) begin
			reach    = reaches[$urandom_range(0, 7)];
			reach_sq = longint'(reach) * reach;
			case ($urandom_range(0, 5))
				0: tol = '0;
				1: tol = TOL_RST;
				2: tol = TOL_MAX;
				3: tol = {1'b0, 8'($urandom), 32'($urandom)};
				default: tol = (reach_sq > longint'(TOL_MAX)) ? TOL_MAX : reach_sq[CFG_DATA_W-1:0];
			endcase
			// Some phases run with no idling at all.
			idle_enabled = ($urandom_range(0, 3) != 0);
			apply_setup(2'($urandom), 1'($urandom), tol);
			repeat ($urandom_range(1, 4))
				send_random_polyline(random_length(), reach);
		end
		idle_enabled = 1'b1;
	endtask

	// Last stretch at full rate on both sides.
	task automatic test_steady_stream();
		int goal;
		idle_enabled = 1'b0;
		apply_setup(DIM_MODE_RST, 1'b1, 41'd1600);
		goal = vertices_sent + STEADY_VERTICES;
		while (vertices_sent < goal)
			send_random_polyline(random_length(), 40);
	endtask

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		vertex    = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_DIM_MODE;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_open_polyline();
		test_dimension_modes();
		test_tolerance_extremes();
		test_closing_trim();
		test_result_backpressure();
		test_random_polylines();
		test_steady_stream();

		wait_drained(DRAIN_CYCLES);
		if (errors == 0)
			$display("polyline_point_dedup_unit test passed");
		else
			$display("polyline_point_dedup_unit test failed");
		$finish;
	end

endmodule
